@@ hw/rtl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants and helpers for the calendar seconds converter.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int unsigned InW  = 66;  // op, elapsed, year, month, day, h, m, s
    localparam int unsigned OutW = 72;  // tdata rounded to bytes
    localparam logic [31:0] LastSecond = 32'd3155759999;
    localparam logic OpToSecs = 1'b0;
    localparam logic OpToDate = 1'b1;

    // Length of a month, with the leap flag for February.
    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] r;
        begin
            case (mo)
                4'd2:                      r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
                default:                   r = 5'd0;
            endcase
            month_len = r;
        end
    endfunction

endpackage

@@ hw/rtl/calendar_seconds_converter_core.sv @@
// ----------------------------------------------------------------------------
// calendar_seconds_converter_core
// Converts between seconds since 2000-01-01 and a calendar date and time.
// ----------------------------------------------------------------------------
// Usage: one request on the slave stream (s_axis_*) gives one result on the
// master stream (m_axis_*). op 0 turns date and time into seconds, op 1 turns
// seconds into date, time and weekday. Out-of-range fields set bad_input and
// zero every other result field; such a result is flagged from S_YR0 or S_DIV.
// Steps: op 0 walks the years, then the months, then takes four accumulate
// steps and one output step. op 1 runs three serial divisions (by 86400, 3600,
// 60), a 13-step weekday reduction, a year walk, a month walk and one output
// step. The year and month walks and the bit-serial divider set how long a
// request takes.
// One request is worked at a time; s_axis_tready rises again once the
// result has left the output register. If the receiver stalls, the result is
// held in that register. Reset returns the sequencer to idle and drops any
// pending result.
module calendar_seconds_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[0], elapsed_in[32:1], year_in[39:33], month_in[43:40], day_in[48:44],
    // hour_in[53:49], minute_in[59:54], second_in[65:60], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // elapsed_out[31:0], year_out[38:32], month_out[42:39], day_out[47:43],
    // hour_out[52:48], minute_out[58:53], second_out[64:59],
    // weekday_out[67:65], bad_input[68], zero fill
    output logic [71:0] m_axis_tdata
);
    import csc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_YR0 = 4'd1, S_MO0 = 4'd2,
                           S_ACC = 4'd3, S_DIV = 4'd4, S_WK = 4'd5,
                           S_YR1 = 4'd6, S_MO1 = 4'd7, S_OUT = 4'd8;

    logic [3:0]  r_st;
    logic        r_op;
    logic [31:0] r_el;
    logic [6:0]  r_yr, r_yi;
    logic [3:0]  r_mo, r_mi;
    logic [4:0]  r_dy, r_hr;
    logic [5:0]  r_mn, r_sc;
    logic [15:0] r_days;
    logic [31:0] r_acc;
    logic [2:0]  r_step;
    logic [3:0]  r_wk;
    logic [15:0] r_wd;
    logic [1:0]  r_dph;
    logic        r_div_go;
    logic [16:0] r_den;
    logic [31:0] r_num;
    logic [71:0] r_out;
    logic        r_ov;
    logic        w_done;
    logic [31:0] w_quo;
    logic [16:0] w_rem;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;
    logic        w_bad0;
    logic [31:0] w_addend;

    csc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_num), .i_den(r_den),
        .o_done(w_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    assign w_leap = (r_yi[1:0] == 2'b00);
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = month_len(r_mi, (r_op == OpToSecs) ? (r_yr[1:0] == 2'b00) : w_leap);
    assign w_bad0 = (r_yr > 7'd99) || (r_mo == 4'd0) || (r_mo > 4'd12) || (r_dy == 5'd0)
                 || (r_dy > month_len(r_mo, r_yr[1:0] == 2'b00)) || (r_hr > 5'd23)
                 || (r_mn > 6'd59) || (r_sc > 6'd59);

    // pick one product term per accumulate step (products by 86400, 3600 and 60)
    always_comb begin
        case (r_step)
            3'd0:    w_addend = 32'(r_days) * 32'd86400;
            3'd1:    w_addend = 32'(r_hr) * 32'd3600;
            3'd2:    w_addend = 32'(r_mn) * 32'd60;
            3'd3:    w_addend = 32'(r_sc);
            default: w_addend = '0;
        endcase
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // sequence one request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ov     <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid && !r_ov) begin
                    r_op <= s_axis_tdata[0];
                    r_el <= s_axis_tdata[32:1];
                    r_yr <= s_axis_tdata[39:33];
                    r_mo <= s_axis_tdata[43:40];
                    r_dy <= s_axis_tdata[48:44];
                    r_hr <= s_axis_tdata[53:49];
                    r_mn <= s_axis_tdata[59:54];
                    r_sc <= s_axis_tdata[65:60];
                    r_yi <= '0;
                    r_mi <= 4'd1;
                    r_days <= '0;
                    r_acc <= '0;
                    r_step <= '0;
                    r_dph <= '0;
                    r_st <= s_axis_tdata[0] ? S_DIV : S_YR0;
                    // start the divider only for a count in range
                    if (s_axis_tdata[0] && (s_axis_tdata[32:1] <= LastSecond)) begin
                        r_num <= s_axis_tdata[32:1];
                        r_den <= 17'd86400;
                        r_div_go <= 1'b1;
                    end
                end
                S_YR0: begin
                    if (w_bad0) begin
                        r_out <= 72'(1) << 68;
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else if (r_yi == r_yr) begin
                        r_st <= S_MO0;
                    end else begin
                        r_days <= r_days + 16'(w_ylen);
                        r_yi   <= r_yi + 7'd1;
                    end
                end
                S_MO0: begin
                    if (r_mi == r_mo) begin
                        r_days <= r_days + 16'(r_dy) - 16'd1;
                        r_st   <= S_ACC;
                    end else begin
                        r_days <= r_days + 16'(w_mlen);
                        r_mi   <= r_mi + 4'd1;
                    end
                end
                S_ACC: begin
                    r_acc  <= r_acc + w_addend;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd3) r_st <= S_OUT;
                end
                S_DIV: begin
                    if (r_el > LastSecond) begin
                        r_out <= 72'(1) << 68;
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else if (w_done) begin
                        r_dph <= r_dph + 2'd1;
                        case (r_dph)
                            2'd0: begin
                                r_days <= w_quo[15:0];
                                r_wd   <= w_quo[15:0] + 16'd6;
                                r_num  <= 32'(w_rem);
                                r_den  <= 17'd3600;
                                r_div_go <= 1'b1;
                            end
                            2'd1: begin
                                r_hr  <= w_quo[4:0];
                                r_num <= 32'(w_rem);
                                r_den <= 17'd60;
                                r_div_go <= 1'b1;
                            end
                            default: begin
                                r_mn   <= w_quo[5:0];
                                r_sc   <= w_rem[5:0];
                                r_wk   <= '0;
                                r_st   <= S_WK;
                            end
                        endcase
                    end
                end
                S_WK: begin
                    // reduce mod 7 by trying 7<<k for k = 12 down to 0, 13 steps
                    if (r_wd >= (16'd7 << (4'd12 - r_wk)))
                        r_wd <= r_wd - (16'd7 << (4'd12 - r_wk));
                    r_wk <= r_wk + 4'd1;
                    if (r_wk == 4'd12) r_st <= S_YR1;
                end
                S_YR1: begin
                    if (r_yi < 7'd99 && r_days >= 16'(w_ylen)) begin
                        r_days <= r_days - 16'(w_ylen);
                        r_yi   <= r_yi + 7'd1;
                    end else begin
                        r_st <= S_MO1;
                    end
                end
                S_MO1: begin
                    if (r_mi < 4'd12 && r_days >= 16'(w_mlen)) begin
                        r_days <= r_days - 16'(w_mlen);
                        r_mi   <= r_mi + 4'd1;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_op == OpToSecs)
                        r_out <= {40'd0, r_acc};
                    else
                        r_out <= {3'd0, 1'b0, r_wd[2:0], r_sc, r_mn, r_hr,
                                  r_days[4:0] + 5'd1, r_mi, r_yi, 32'd0};
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // hold off new requests while a request is being worked
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_out))) else $error("result lost");
    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out[68] == 1'b0) |-> (r_out[67:65] <= 3'd6)) else $error("weekday range");
endmodule

@@ hw/rtl/csc_divider.sv @@
// ----------------------------------------------------------------------------
// csc_divider
// Bit-serial restoring divider: one quotient bit per cycle over 32 numerator bits.
// ----------------------------------------------------------------------------
module csc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [16:0] o_rem
);
    logic [31:0] r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_try;
    logic [18:0] w_diff;

    // shift in the next numerator bit and trial-subtract
    assign w_try  = {r_rem[16:0], r_quo[31]};
    assign w_diff = {1'b0, w_try} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_diff[18]) begin
                    r_rem <= w_try;
                    r_quo <= {r_quo[30:0], 1'b0};
                end else begin
                    r_rem <= w_diff[17:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[16:0];
endmodule
